// ----- sv/fsmc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsmc_pkg
// Shared types and constants of the flux sync-mark classifier.
// ----------------------------------------------------------------------------
package fsmc_pkg;

    localparam int COUNT_BITS_DEF = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MFM_DETECT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MFM_STRONG = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FM_DETECT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FM_STRONG  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GCR_DETECT = 3'd4;

    localparam logic [7:0] MFM_DETECT_RST = 8'd5;
    localparam logic [7:0] MFM_STRONG_RST = 8'd15;
    localparam logic [7:0] FM_DETECT_RST  = 8'd5;
    localparam logic [7:0] FM_STRONG_RST  = 8'd10;
    localparam logic [7:0] GCR_DETECT_RST = 8'd20;

    localparam logic [7:0] BYTE_MFM_MARK = 8'hA1;
    localparam logic [7:0] BYTE_FM_FIRST = 8'hF5;
    localparam logic [7:0] BYTE_FM_LAST  = 8'h7E;
    localparam logic [7:0] BYTE_GCR_MARK = 8'hFF;

    localparam logic [1:0] KIND_MFM  = 2'd0;
    localparam logic [1:0] KIND_FM   = 2'd1;
    localparam logic [1:0] KIND_GCR  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [6:0] CONF_MFM_HIGH = 7'd85;
    localparam logic [6:0] CONF_MFM_LOW  = 7'd60;
    localparam logic [6:0] CONF_FM_HIGH  = 7'd80;
    localparam logic [6:0] CONF_FM_LOW   = 7'd55;
    localparam logic [6:0] CONF_GCR      = 7'd70;
    localparam logic [6:0] CONF_NONE     = 7'd0;

    typedef struct packed {
        logic [7:0] mfm_detect;
        logic [7:0] mfm_strong;
        logic [7:0] fm_detect;
        logic [7:0] fm_strong;
        logic [7:0] gcr_detect;
    } t_cfg;

    // hit has one bit per result kind, indexed by the kind code.
    typedef struct packed {
        logic [3:0] hit;
        logic       mfm_strong;
        logic       fm_strong;
    } t_verdict;

endpackage

// ----- sv/fsmc_tracker.sv -----
// ----------------------------------------------------------------------------
// fsmc_tracker
// Sync-mark matchers and saturating counters; scores the buffer on its last
// byte and clears the run.
// ----------------------------------------------------------------------------
module fsmc_tracker #(
    parameter int COUNT_BITS = fsmc_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_flux_byte,
    input  logic              i_end_of_buffer,
    input  fsmc_pkg::t_cfg    i_cfg,
    output fsmc_pkg::t_verdict o_verdict
);

    localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [1:0]            r_mfm_phase, n_mfm_phase;
    logic                  r_fm_after_f5, n_fm_after_f5;
    logic                  r_gcr_phase, n_gcr_phase;
    logic [2:0]            r_gcr_pending, n_gcr_pending;
    logic [COUNT_BITS-1:0] r_mfm_count, n_mfm_count;
    logic [COUNT_BITS-1:0] r_fm_count, n_fm_count;
    logic [COUNT_BITS-1:0] r_gcr_count, n_gcr_count;
    logic                  pair_now;
    logic                  mfm_hit, fm_hit, gcr_hit;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    always_comb begin
        n_mfm_phase   = r_mfm_phase;
        n_fm_after_f5 = r_fm_after_f5;
        n_gcr_phase   = r_gcr_phase;
        n_mfm_count   = r_mfm_count;
        n_fm_count    = r_fm_count;
        n_gcr_count   = r_gcr_count;
        pair_now      = 1'b0;

        if (i_flux_byte == fsmc_pkg::BYTE_MFM_MARK) begin
            if (r_mfm_phase >= 2'd2) begin
                n_mfm_count = sat_inc(r_mfm_count);
                n_mfm_phase = 2'd0;
            end else begin
                n_mfm_phase = r_mfm_phase + 2'd1;
            end
        end else begin
            n_mfm_phase = 2'd0;
        end

        if (i_flux_byte == fsmc_pkg::BYTE_FM_LAST && r_fm_after_f5) begin
            n_fm_count    = sat_inc(r_fm_count);
            n_fm_after_f5 = 1'b0;
        end else begin
            n_fm_after_f5 = (i_flux_byte == fsmc_pkg::BYTE_FM_FIRST);
        end

        if (r_gcr_pending[2]) begin
            n_gcr_count = sat_inc(r_gcr_count);
        end
        if (i_flux_byte == fsmc_pkg::BYTE_GCR_MARK) begin
            pair_now    = r_gcr_phase;
            n_gcr_phase = !r_gcr_phase;
        end else begin
            n_gcr_phase = 1'b0;
        end
        n_gcr_pending = {r_gcr_pending[1:0], pair_now};
    end

    assign mfm_hit = CMP_W'(n_mfm_count) > CMP_W'(i_cfg.mfm_detect);
    assign fm_hit  = CMP_W'(n_fm_count) > CMP_W'(i_cfg.fm_detect);
    assign gcr_hit = CMP_W'(n_gcr_count) > CMP_W'(i_cfg.gcr_detect);

    always_comb begin
        o_verdict                           = '0;
        o_verdict.hit[fsmc_pkg::KIND_MFM]  = mfm_hit;
        o_verdict.hit[fsmc_pkg::KIND_FM]   = fm_hit;
        o_verdict.hit[fsmc_pkg::KIND_GCR]  = gcr_hit;
        o_verdict.hit[fsmc_pkg::KIND_NONE] = !(mfm_hit || fm_hit || gcr_hit);
        o_verdict.mfm_strong = CMP_W'(n_mfm_count) > CMP_W'(i_cfg.mfm_strong);
        o_verdict.fm_strong  = CMP_W'(n_fm_count) > CMP_W'(i_cfg.fm_strong);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end_of_buffer)) begin
            r_mfm_phase   <= '0;
            r_fm_after_f5 <= 1'b0;
            r_gcr_phase   <= 1'b0;
            r_gcr_pending <= '0;
            r_mfm_count   <= '0;
            r_fm_count    <= '0;
            r_gcr_count   <= '0;
        end else if (i_take) begin
            r_mfm_phase   <= n_mfm_phase;
            r_fm_after_f5 <= n_fm_after_f5;
            r_gcr_phase   <= n_gcr_phase;
            r_gcr_pending <= n_gcr_pending;
            r_mfm_count   <= n_mfm_count;
            r_fm_count    <= n_fm_count;
            r_gcr_count   <= n_gcr_count;
        end
    end

endmodule

// ----- sv/flux_sync_mark_classifier.sv -----
// ----------------------------------------------------------------------------
// flux_sync_mark_classifier
// Counts MFM, FM and GCR sync marks in a flux buffer and scores the encodings.
// ----------------------------------------------------------------------------
// Usage: flux bytes arrive on the input channel, one per transfer, with
// i_end_of_buffer set on the final byte of a buffer. Every byte updates the
// mark matchers and counters as it is taken, so a new byte is accepted in
// every cycle unless a final byte waits. The final byte scores the buffer into
// a report register and clears the run; the report then leaves on the output
// channel as one to three results in MFM, FM, GCR order, or a single "none"
// result, one per cycle while the receiver is ready, the first in the cycle
// after the final byte. The last result of a buffer carries o_last_result.
// Bytes of the next buffer keep flowing while a report drains; only a final
// byte waits, with o_in_ready low, until the previous report has left or is
// leaving in the same cycle. A stalled receiver holds the current result.
// Configuration writes are taken in every cycle and belong only to idle
// periods. Reset clears the run, empties the report and loads the default
// thresholds.
// ----------------------------------------------------------------------------
module flux_sync_mark_classifier #(
    parameter int COUNT_BITS = fsmc_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_flux_byte,
    input  logic                                i_end_of_buffer,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_encoding_kind,
    output logic [6:0]                          o_confidence,
    output logic                                o_last_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fsmc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [fsmc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    fsmc_pkg::t_cfg     r_cfg;
    fsmc_pkg::t_verdict verdict;
    logic [3:0]         r_mask, n_mask;
    logic               r_mfm_strong;
    logic               r_fm_strong;
    logic               in_take, out_take, out_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mfm_detect <= fsmc_pkg::MFM_DETECT_RST;
            r_cfg.mfm_strong <= fsmc_pkg::MFM_STRONG_RST;
            r_cfg.fm_detect  <= fsmc_pkg::FM_DETECT_RST;
            r_cfg.fm_strong  <= fsmc_pkg::FM_STRONG_RST;
            r_cfg.gcr_detect <= fsmc_pkg::GCR_DETECT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fsmc_pkg::REG_MFM_DETECT: r_cfg.mfm_detect <= i_cfg_data;
                fsmc_pkg::REG_MFM_STRONG: r_cfg.mfm_strong <= i_cfg_data;
                fsmc_pkg::REG_FM_DETECT:  r_cfg.fm_detect  <= i_cfg_data;
                fsmc_pkg::REG_FM_STRONG:  r_cfg.fm_strong  <= i_cfg_data;
                fsmc_pkg::REG_GCR_DETECT: r_cfg.gcr_detect <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_take   = o_out_valid && i_out_ready;
    assign out_done   = out_take && o_last_result;
    assign o_in_ready = !(i_end_of_buffer && o_out_valid && !out_done);
    assign in_take    = i_in_valid && o_in_ready;

    fsmc_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (in_take),
        .i_flux_byte     (i_flux_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_cfg           (r_cfg),
        .o_verdict       (verdict)
    );

    always_comb begin
        n_mask = r_mask;
        priority if (in_take && i_end_of_buffer) begin
            n_mask = verdict.hit;
        end else if (out_take) begin
            n_mask = r_mask & (r_mask - 4'd1);
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_end_of_buffer) begin
            r_mfm_strong <= verdict.mfm_strong;
            r_fm_strong  <= verdict.fm_strong;
        end
    end

    assign o_out_valid   = |r_mask;
    assign o_last_result = (r_mask & (r_mask - 4'd1)) == 4'd0;

    always_comb begin
        priority if (r_mask[fsmc_pkg::KIND_MFM]) begin
            o_encoding_kind = fsmc_pkg::KIND_MFM;
            o_confidence    = r_mfm_strong ? fsmc_pkg::CONF_MFM_HIGH : fsmc_pkg::CONF_MFM_LOW;
        end else if (r_mask[fsmc_pkg::KIND_FM]) begin
            o_encoding_kind = fsmc_pkg::KIND_FM;
            o_confidence    = r_fm_strong ? fsmc_pkg::CONF_FM_HIGH : fsmc_pkg::CONF_FM_LOW;
        end else if (r_mask[fsmc_pkg::KIND_GCR]) begin
            o_encoding_kind = fsmc_pkg::KIND_GCR;
            o_confidence    = fsmc_pkg::CONF_GCR;
        end else begin
            o_encoding_kind = fsmc_pkg::KIND_NONE;
            o_confidence    = fsmc_pkg::CONF_NONE;
        end
    end

endmodule

// ----- sv/fsmc_checker.sv -----
// ----------------------------------------------------------------------------
// fsmc_checker
// Port-level checks of the flux sync-mark classifier, bound to the top level.
// ----------------------------------------------------------------------------
module fsmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       i_end_of_buffer,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_encoding_kind,
    input logic [6:0] o_confidence,
    input logic       o_last_result
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_encoding_kind)
            && $stable(o_confidence) && $stable(o_last_result))
        else $error("stalled result changed");

    a_only_final_byte_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> i_end_of_buffer && o_out_valid)
        else $error("input stalled without a pending report");

    a_none_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_encoding_kind == fsmc_pkg::KIND_NONE
            |-> o_last_result && o_confidence == fsmc_pkg::CONF_NONE)
        else $error("none result malformed");

    a_mfm_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_encoding_kind == fsmc_pkg::KIND_MFM
            |-> o_confidence == fsmc_pkg::CONF_MFM_HIGH
                || o_confidence == fsmc_pkg::CONF_MFM_LOW)
        else $error("MFM confidence out of set");

endmodule

bind flux_sync_mark_classifier fsmc_checker u_fsmc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .i_end_of_buffer (i_end_of_buffer),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_encoding_kind (o_encoding_kind),
    .o_confidence    (o_confidence),
    .o_last_result   (o_last_result)
);

// ----- bench/tb_flux_sync_mark_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flux_sync_mark_classifier
// Streams flux buffers through the classifier and checks every scored result.
// A short table of directed buffers covers the reset thresholds, the all-zero
// and all-ones thresholds, unconfirmed GCR pairs and greedy matching. A long
// buffer then drives all three mark counters into saturation. Random phases
// follow, each with fresh thresholds and buffers built mostly from sync-mark
// fragments. A local scoring model predicts each result, and the checker
// compares every output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_flux_sync_mark_classifier;

    localparam int MARK_BITS = fsmc_pkg::COUNT_BITS_DEF;
    localparam int IDX_BITS = fsmc_pkg::CFG_INDEX_BITS;
    localparam int RANDOM_ITEMS = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int SATURATE_REPS = 260;
    localparam logic [IDX_BITS-1:0] REG_PAST_LIST = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_INDEX_TOP = '1;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] conf;
        logic       is_last;
    } t_mark_report;

    localparam t_mark_report NO_REPORT = '0;

    typedef enum logic {ROW_FLUX, ROW_CONFIG} t_row_op;

    typedef struct {
        t_row_op             op;
        logic [7:0]          value;
        logic                eob;
        logic [IDX_BITS-1:0] reg_index;
        logic                typed;
        t_mark_report        want;
    } t_stim_row;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} t_sink_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [7:0]                         i_flux_byte = '0;
    logic                               i_end_of_buffer = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [1:0]                         o_encoding_kind;
    logic [6:0]                         o_confidence;
    logic                               o_last_result;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [IDX_BITS-1:0]                i_cfg_index = '0;
    logic [fsmc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    fsmc_pkg::t_cfg        thresholds;
    logic [1:0]            a1_run;
    logic                  saw_f5;
    logic                  ff_open;
    logic [2:0]            ff_pending;
    logic [MARK_BITS-1:0]  mfm_marks;
    logic [MARK_BITS-1:0]  fm_marks;
    logic [MARK_BITS-1:0]  gcr_marks;

    t_mark_report pending_reports[$];
    t_mark_report scored_now[$];
    t_stim_row    directed_rows[$];
    logic [7:0]   flux_run[$];

    int         mismatch_count = 0;
    int         random_items = 0;
    int         burst_left = 0;
    bit         cfg_open = 1'b0;
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left = 0;

    always #2 i_clk = ~i_clk;

    flux_sync_mark_classifier #(
        .COUNT_BITS(MARK_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_flux_byte(i_flux_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_encoding_kind(o_encoding_kind),
        .o_confidence(o_confidence),
        .o_last_result(o_last_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    function automatic logic [MARK_BITS-1:0] saturating_bump(input logic [MARK_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic t_mark_report make_report(input logic [1:0] kind, input logic [6:0] conf,
                                                 input logic is_last);
        t_mark_report r;
        r.kind = kind;
        r.conf = conf;
        r.is_last = is_last;
        return r;
    endfunction

    function automatic void clear_marks();
        a1_run = '0;
        saw_f5 = 1'b0;
        ff_open = 1'b0;
        ff_pending = '0;
        mfm_marks = '0;
        fm_marks = '0;
        gcr_marks = '0;
    endfunction

    function automatic void score_flux_byte(input logic [7:0] b, input logic eob);
        logic pair_done;
        logic mfm_hit;
        logic fm_hit;
        logic gcr_hit;
        pair_done = 1'b0;
        scored_now.delete();

        if (b == fsmc_pkg::BYTE_MFM_MARK) begin
            if (a1_run >= 2'd2) begin
                mfm_marks = saturating_bump(mfm_marks);
                a1_run = '0;
            end else begin
                a1_run = a1_run + 2'd1;
            end
        end else begin
            a1_run = '0;
        end

        if (b == fsmc_pkg::BYTE_FM_LAST && saw_f5) begin
            fm_marks = saturating_bump(fm_marks);
            saw_f5 = 1'b0;
        end else begin
            saw_f5 = (b == fsmc_pkg::BYTE_FM_FIRST);
        end

        if (ff_pending[2]) begin
            gcr_marks = saturating_bump(gcr_marks);
        end
        if (b == fsmc_pkg::BYTE_GCR_MARK) begin
            if (ff_open) begin
                pair_done = 1'b1;
                ff_open = 1'b0;
            end else begin
                ff_open = 1'b1;
            end
        end else begin
            ff_open = 1'b0;
        end
        ff_pending = {ff_pending[1:0], pair_done};

        if (eob) begin
            mfm_hit = (mfm_marks > thresholds.mfm_detect);
            fm_hit = (fm_marks > thresholds.fm_detect);
            gcr_hit = (gcr_marks > thresholds.gcr_detect);
            if (mfm_hit) begin
                scored_now.push_back(make_report(fsmc_pkg::KIND_MFM,
                    (mfm_marks > thresholds.mfm_strong) ? fsmc_pkg::CONF_MFM_HIGH
                                                        : fsmc_pkg::CONF_MFM_LOW,
                    !(fm_hit || gcr_hit)));
            end
            if (fm_hit) begin
                scored_now.push_back(make_report(fsmc_pkg::KIND_FM,
                    (fm_marks > thresholds.fm_strong) ? fsmc_pkg::CONF_FM_HIGH
                                                      : fsmc_pkg::CONF_FM_LOW,
                    !gcr_hit));
            end
            if (gcr_hit) begin
                scored_now.push_back(make_report(fsmc_pkg::KIND_GCR, fsmc_pkg::CONF_GCR, 1'b1));
            end
            if (!(mfm_hit || fm_hit || gcr_hit)) begin
                scored_now.push_back(make_report(fsmc_pkg::KIND_NONE, fsmc_pkg::CONF_NONE,
                                                 1'b1));
            end
            clear_marks();
        end
    endfunction

    function automatic void add_flux(input logic [7:0] value, input logic eob);
        t_stim_row r;
        r.op = ROW_FLUX;
        r.value = value;
        r.eob = eob;
        r.reg_index = '0;
        r.typed = 1'b0;
        r.want = NO_REPORT;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input logic [7:0] value, input logic [1:0] kind,
                                      input logic [6:0] conf);
        t_stim_row r;
        r.op = ROW_FLUX;
        r.value = value;
        r.eob = 1'b1;
        r.reg_index = '0;
        r.typed = 1'b1;
        r.want = make_report(kind, conf, 1'b1);
        directed_rows.push_back(r);
    endfunction

    function automatic void add_config(input logic [IDX_BITS-1:0] idx,
                                       input logic [7:0] value);
        t_stim_row r;
        r.op = ROW_CONFIG;
        r.value = value;
        r.eob = 1'b0;
        r.reg_index = idx;
        r.typed = 1'b0;
        r.want = NO_REPORT;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [7:0] pick_threshold();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'hFF;
            2, 3: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_BITS-1:0] idx, input logic [7:0] data);
        if (!cfg_open) begin
            settle_idle();
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_open = 1'b1;
        case (idx)
            fsmc_pkg::REG_MFM_DETECT: thresholds.mfm_detect = data;
            fsmc_pkg::REG_MFM_STRONG: thresholds.mfm_strong = data;
            fsmc_pkg::REG_FM_DETECT:  thresholds.fm_detect = data;
            fsmc_pkg::REG_FM_STRONG:  thresholds.fm_strong = data;
            fsmc_pkg::REG_GCR_DETECT: thresholds.gcr_detect = data;
            default: ;
        endcase
    endtask

    task automatic transfer_flux(input logic [7:0] b, input logic eob, input logic typed,
                                 input t_mark_report want);
        int gap;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_flux_byte <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        burst_left--;
        score_flux_byte(b, eob);
        if (typed && eob) begin
            pending_reports.push_back(want);
        end else begin
            foreach (scored_now[k]) pending_reports.push_back(scored_now[k]);
        end
    endtask

    task automatic send_run();
        foreach (flux_run[k]) begin
            transfer_flux(flux_run[k], k == flux_run.size() - 1, 1'b0, NO_REPORT);
        end
    endtask

    task automatic send_random_buffer();
        int len;
        logic [7:0] noise;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
        flux_run.delete();
        while (flux_run.size() < len) begin
            noise = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 11))
                4: begin
                    repeat (3) flux_run.push_back(fsmc_pkg::BYTE_MFM_MARK);
                end
                5: begin
                    flux_run.push_back(fsmc_pkg::BYTE_FM_FIRST);
                    flux_run.push_back(fsmc_pkg::BYTE_FM_LAST);
                end
                6: begin
                    repeat (2) flux_run.push_back(fsmc_pkg::BYTE_GCR_MARK);
                end
                7: begin
                    repeat (2) flux_run.push_back(fsmc_pkg::BYTE_MFM_MARK);
                    flux_run.push_back(noise);
                end
                8: begin
                    flux_run.push_back(fsmc_pkg::BYTE_FM_FIRST);
                    flux_run.push_back(noise);
                end
                9: begin
                    flux_run.push_back(fsmc_pkg::BYTE_GCR_MARK);
                    flux_run.push_back(noise);
                end
                10: begin
                    repeat (3) flux_run.push_back(fsmc_pkg::BYTE_GCR_MARK);
                end
                11: begin
                    repeat (4) flux_run.push_back(fsmc_pkg::BYTE_MFM_MARK);
                end
                default: flux_run.push_back(noise);
            endcase
        end
        while (flux_run.size() > len) void'(flux_run.pop_back());
        random_items += len;
        send_run();
    endtask

    task automatic configure_random();
        write_register(fsmc_pkg::REG_MFM_DETECT, pick_threshold());
        write_register(fsmc_pkg::REG_MFM_STRONG, pick_threshold());
        write_register(fsmc_pkg::REG_FM_DETECT, pick_threshold());
        write_register(fsmc_pkg::REG_FM_STRONG, pick_threshold());
        write_register(fsmc_pkg::REG_GCR_DETECT, pick_threshold());
        if ($urandom_range(0, 2) == 0) begin
            write_register(IDX_BITS'($urandom_range(REG_PAST_LIST, REG_INDEX_TOP)),
                           8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(16, 128);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   i_out_ready <= 1'b1;
            SINK_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:     i_out_ready <= ~i_out_ready;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_mark_report want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result transfer with nothing expected: kind %0d conf %0d last %b",
                         $time, o_encoding_kind, o_confidence, o_last_result);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_encoding_kind !== want.kind) begin
                    $display("%0t: encoding_kind expected %0d actual %0d",
                             $time, want.kind, o_encoding_kind);
                    mismatch_count++;
                end
                if (o_confidence !== want.conf) begin
                    $display("%0t: confidence expected %0d actual %0d",
                             $time, want.conf, o_confidence);
                    mismatch_count++;
                end
                if (o_last_result !== want.is_last) begin
                    $display("%0t: last_result expected %b actual %b",
                             $time, want.is_last, o_last_result);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_stim_row r;
        thresholds.mfm_detect = fsmc_pkg::MFM_DETECT_RST;
        thresholds.mfm_strong = fsmc_pkg::MFM_STRONG_RST;
        thresholds.fm_detect = fsmc_pkg::FM_DETECT_RST;
        thresholds.fm_strong = fsmc_pkg::FM_STRONG_RST;
        thresholds.gcr_detect = fsmc_pkg::GCR_DETECT_RST;
        clear_marks();

        add_typed(8'h00, fsmc_pkg::KIND_NONE, fsmc_pkg::CONF_NONE);
        add_typed(8'hFF, fsmc_pkg::KIND_NONE, fsmc_pkg::CONF_NONE);
        add_config(fsmc_pkg::REG_MFM_DETECT, 8'd0);
        add_config(fsmc_pkg::REG_MFM_STRONG, 8'd0);
        add_config(fsmc_pkg::REG_FM_DETECT, 8'd0);
        add_config(fsmc_pkg::REG_FM_STRONG, 8'd0);
        add_config(fsmc_pkg::REG_GCR_DETECT, 8'd0);
        add_config(REG_INDEX_TOP, 8'hFF);
        add_flux(fsmc_pkg::BYTE_MFM_MARK, 1'b0);
        add_flux(fsmc_pkg::BYTE_MFM_MARK, 1'b0);
        add_flux(fsmc_pkg::BYTE_MFM_MARK, 1'b0);
        add_flux(fsmc_pkg::BYTE_FM_FIRST, 1'b0);
        add_flux(fsmc_pkg::BYTE_FM_LAST, 1'b0);
        add_flux(fsmc_pkg::BYTE_GCR_MARK, 1'b0);
        add_flux(fsmc_pkg::BYTE_GCR_MARK, 1'b0);
        add_flux(8'h00, 1'b0);
        add_flux(8'h00, 1'b0);
        add_flux(8'h55, 1'b1);
        // A pair followed by only two bytes is dropped at the end of the buffer.
        add_flux(fsmc_pkg::BYTE_GCR_MARK, 1'b0);
        add_flux(fsmc_pkg::BYTE_GCR_MARK, 1'b0);
        add_flux(8'h00, 1'b0);
        add_typed(8'h00, fsmc_pkg::KIND_NONE, fsmc_pkg::CONF_NONE);
        repeat (4) add_flux(fsmc_pkg::BYTE_MFM_MARK, 1'b0);
        add_typed(fsmc_pkg::BYTE_MFM_MARK, fsmc_pkg::KIND_MFM, fsmc_pkg::CONF_MFM_HIGH);
        add_flux(fsmc_pkg::BYTE_FM_FIRST, 1'b0);
        add_flux(fsmc_pkg::BYTE_FM_FIRST, 1'b0);
        add_typed(fsmc_pkg::BYTE_FM_LAST, fsmc_pkg::KIND_FM, fsmc_pkg::CONF_FM_HIGH);
        add_config(fsmc_pkg::REG_MFM_DETECT, 8'hFF);
        add_config(fsmc_pkg::REG_MFM_STRONG, 8'hFF);
        add_config(fsmc_pkg::REG_FM_DETECT, 8'hFF);
        add_config(fsmc_pkg::REG_FM_STRONG, 8'hFF);
        add_config(fsmc_pkg::REG_GCR_DETECT, 8'hFF);
        add_typed(fsmc_pkg::BYTE_FM_LAST, fsmc_pkg::KIND_NONE, fsmc_pkg::CONF_NONE);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.op == ROW_CONFIG) begin
                write_register(r.reg_index, r.value);
            end else begin
                transfer_flux(r.value, r.eob, r.typed, r.want);
            end
        end

        // One long buffer drives every counter up to its all-ones value, where it saturates.
        write_register(fsmc_pkg::REG_MFM_DETECT, 8'd254);
        write_register(fsmc_pkg::REG_MFM_STRONG, 8'hFF);
        write_register(fsmc_pkg::REG_FM_DETECT, 8'hFF);
        write_register(fsmc_pkg::REG_FM_STRONG, 8'd0);
        write_register(fsmc_pkg::REG_GCR_DETECT, 8'd254);
        flux_run.delete();
        repeat (SATURATE_REPS) begin
            repeat (3) flux_run.push_back(fsmc_pkg::BYTE_MFM_MARK);
            flux_run.push_back(fsmc_pkg::BYTE_FM_FIRST);
            flux_run.push_back(fsmc_pkg::BYTE_FM_LAST);
            repeat (2) flux_run.push_back(fsmc_pkg::BYTE_GCR_MARK);
        end
        flux_run.push_back(8'h00);
        flux_run.push_back(8'h00);
        flux_run.push_back(8'h3C);
        send_run();

        while (random_items < RANDOM_ITEMS) begin
            configure_random();
            repeat ($urandom_range(2, 6)) send_random_buffer();
        end

        settle_idle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/fsmc_pkg.sv
sv/fsmc_tracker.sv
sv/flux_sync_mark_classifier.sv
sv/fsmc_checker.sv
bench/tb_flux_sync_mark_classifier.sv
